### hdl/infix_expression_evaluator_assert.svh
// Assertion macros for the infix expression evaluator checker
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define IEE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define IEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset
`define IEE_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Types and constants shared by the infix expression evaluator modules.
// ----------------------------------------------------------------------------
package iee_pkg;

    // characters
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // operator codes held in the term flags
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // term flag bits
    localparam int FL_HAS = 0;
    localparam int FL_NEG = 1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_DEEP    = 2'd2;
    localparam logic [1:0] ST_BADBYTE = 2'd3;

    typedef enum logic [2:0] {
        CLS_SPACE, CLS_DIGIT, CLS_OP, CLS_OPEN, CLS_CLOSE, CLS_OTHER
    } t_iee_cls;

    typedef enum logic [1:0] {
        MODE_BYTE, MODE_CLOSE, MODE_FINAL
    } t_iee_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_PUSH, S_DIVW, S_PUSHQ, S_FIN, S_POP, S_END, S_EMIT
    } t_iee_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic digit;
        logic push;
        logic push_add;
        logic open_frame;
        logic deep;
        logic badbyte;
        logic fin;
        logic fin_close;
        logic pop;
        logic div_start;
        logic save_stop;
        logic emit;
    } t_iee_cmd;

    // datapath to controller
    typedef struct packed {
        logic     accept;
        t_iee_cls cls;
        logic     last;
        logic     stopped;
        logic     need_div;
        logic     level_zero;
        logic     level_full;
        logic     div_done;
        logic     out_free;
    } t_iee_stat;

endpackage

### hdl/iee_if.sv
// ----------------------------------------------------------------------------
// iee_in_if / iee_out_if
// Valid/ready channels for expression bytes and for results.
// ----------------------------------------------------------------------------
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last;

    modport source (output valid, char_in, last, input ready);
    modport sink   (input valid, char_in, last, output ready);
endinterface

interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic [1:0]         status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

### hdl/iee_divider.sv
// ----------------------------------------------------------------------------
// iee_divider
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic        r_neg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    // shift in the next dividend bit and trial subtract
    assign rem_sh  = {r_rem[31:0], r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // magnitudes on start, then restoring steps
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_div <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!rem_sub[32]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

### hdl/iee_datapath.sv
// ----------------------------------------------------------------------------
// iee_datapath
// Term registers, frame stack memory, divider and result register.
// ----------------------------------------------------------------------------
module iee_datapath #(
    parameter int MAX_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iee_pkg::t_iee_cmd i_cmd,
    output iee_pkg::t_iee_stat o_stat,
    iee_in_if.sink            i_in,
    iee_out_if.source         o_out
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [7:0]  r_char;
    logic        r_last;
    logic [31:0] r_total;
    logic [31:0] r_term;
    logic [31:0] r_num;
    logic [3:0]  r_flags;
    logic [LW-1:0] r_level;
    logic        r_stopped;
    logic [1:0]  r_err;
    logic [31:0] r_value;
    logic        r_out_valid;
    logic [31:0] r_out_result;
    logic [1:0]  r_out_status;

    logic [67:0] mem [MAX_DEPTH];
    logic [67:0] r_rd;

    logic        div_done;
    logic [31:0] quotient;
    logic [1:0]  prev_op;
    logic [1:0]  push_op;
    logic [1:0]  char_op;
    logic [31:0] product;
    logic [31:0] signed_term;
    logic [31:0] frame_value;
    logic [LW-1:0] level_dec;
    iee_pkg::t_iee_cls cls;

    // byte classification
    always_comb begin
        char_op = iee_pkg::OP_ADD;
        case (r_char)
            iee_pkg::CH_SUB: char_op = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: char_op = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: char_op = iee_pkg::OP_DIV;
            default:         char_op = iee_pkg::OP_ADD;
        endcase
        if (r_char == iee_pkg::CH_SPACE)
            cls = iee_pkg::CLS_SPACE;
        else if (r_char >= iee_pkg::CH_ZERO && r_char <= iee_pkg::CH_NINE)
            cls = iee_pkg::CLS_DIGIT;
        else if (r_char == iee_pkg::CH_ADD || r_char == iee_pkg::CH_SUB ||
                 r_char == iee_pkg::CH_MUL || r_char == iee_pkg::CH_DIV)
            cls = iee_pkg::CLS_OP;
        else if (r_char == iee_pkg::CH_OPEN)
            cls = iee_pkg::CLS_OPEN;
        else if (r_char == iee_pkg::CH_CLOSE)
            cls = iee_pkg::CLS_CLOSE;
        else
            cls = iee_pkg::CLS_OTHER;
    end

    assign prev_op     = r_flags[3:2];
    assign push_op     = i_cmd.push_add ? iee_pkg::OP_ADD : char_op;
    assign product     = r_term * r_num;
    assign signed_term = r_flags[iee_pkg::FL_NEG] ? (32'd0 - r_term) : r_term;
    assign frame_value = r_total + signed_term;
    assign level_dec   = r_level - LW'(1);

    iee_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_term),
        .i_divisor  (r_num),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // input latch
    assign i_in.ready = i_cmd.in_ready;
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_cmd.in_ready) begin
            r_char <= i_in.char_in;
            r_last <= i_in.last;
        end
    end

    // frame stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.open_frame)
            mem[r_level[AW-1:0]] <= {r_total, r_term, r_flags};
        if (i_cmd.fin)
            r_rd <= mem[level_dec[AW-1:0]];
    end

    // term state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_total   <= '0;
            r_term    <= '0;
            r_num     <= '0;
            r_flags   <= '0;
            r_level   <= '0;
            r_stopped <= 1'b0;
            r_err     <= iee_pkg::ST_OK;
        end else begin
            if (i_cmd.digit)
                r_num <= (r_num << 3) + (r_num << 1) + {28'd0, r_char[3:0]};
            if (i_cmd.push) begin
                r_num <= '0;
                r_flags[iee_pkg::FL_HAS] <= 1'b1;
                r_flags[3:2] <= push_op;
                if (r_flags[iee_pkg::FL_HAS] && prev_op[1]) begin
                    if (prev_op == iee_pkg::OP_MUL) begin
                        r_term <= product;
                    end else if (r_num == 32'd0) begin
                        r_term <= '0;
                        if (r_err == iee_pkg::ST_OK)
                            r_err <= iee_pkg::ST_DIVZERO;
                    end else begin
                        r_term <= quotient;
                    end
                end else begin
                    r_term <= r_num;
                    r_flags[iee_pkg::FL_NEG] <= r_flags[iee_pkg::FL_HAS] &&
                                                (prev_op == iee_pkg::OP_SUB);
                    if (r_flags[iee_pkg::FL_HAS])
                        r_total <= frame_value;
                end
            end
            if (i_cmd.open_frame) begin
                r_level <= r_level + LW'(1);
                r_total <= '0;
                r_term  <= '0;
                r_flags <= '0;
                r_num   <= '0;
            end
            if (i_cmd.deep) begin
                r_stopped <= 1'b1;
                if (r_err == iee_pkg::ST_OK)
                    r_err <= iee_pkg::ST_DEEP;
            end
            if (i_cmd.badbyte && r_err == iee_pkg::ST_OK)
                r_err <= iee_pkg::ST_BADBYTE;
            if (i_cmd.fin) begin
                if (r_level != '0)
                    r_num <= frame_value;
                else if (i_cmd.fin_close) begin
                    r_total   <= frame_value;
                    r_stopped <= 1'b1;
                end
            end
            if (i_cmd.pop) begin
                r_level <= level_dec;
                r_total <= r_rd[67:36];
                r_term  <= r_rd[35:4];
                r_flags <= r_rd[3:0];
            end
        end
    end

    // value for the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_stop)
            r_value <= r_total;
        else if (i_cmd.fin)
            r_value <= frame_value;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_result <= (r_err != iee_pkg::ST_OK) ? 32'd0 : r_value;
            r_out_status <= r_err;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out_result;
    assign o_out.status = r_out_status;

    // status to the controller
    always_comb begin
        o_stat.accept     = i_in.valid && i_cmd.in_ready;
        o_stat.cls        = cls;
        o_stat.last       = r_last;
        o_stat.stopped    = r_stopped;
        o_stat.need_div   = r_flags[iee_pkg::FL_HAS] && (prev_op == iee_pkg::OP_DIV) &&
                            (r_num != 32'd0);
        o_stat.level_zero = (r_level == '0);
        o_stat.level_full = (r_level >= LW'(MAX_DEPTH));
        o_stat.div_done   = div_done;
        o_stat.out_free   = !r_out_valid || o_out.ready;
    end

endmodule

### hdl/iee_ctrl.sv
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer: byte decode, term folding, frame close and result hand-off.
// ----------------------------------------------------------------------------
module iee_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iee_pkg::t_iee_stat i_stat,
    output iee_pkg::t_iee_cmd  o_cmd
);

    iee_pkg::t_iee_state r_state, n_state;
    iee_pkg::t_iee_mode  r_mode, n_mode;
    iee_pkg::t_iee_state after_byte;
    iee_pkg::t_iee_state after_push;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iee_pkg::S_IDLE;
            r_mode  <= iee_pkg::MODE_BYTE;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign after_byte = i_stat.last ? iee_pkg::S_END : iee_pkg::S_IDLE;
    assign after_push = (r_mode == iee_pkg::MODE_BYTE) ? after_byte : iee_pkg::S_FIN;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '0;
        unique case (r_state)
            iee_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.accept)
                    n_state = iee_pkg::S_EXEC;
            end
            iee_pkg::S_EXEC: begin
                n_state = after_byte;
                if (!i_stat.stopped) begin
                    unique case (i_stat.cls)
                        iee_pkg::CLS_DIGIT: o_cmd.digit = 1'b1;
                        iee_pkg::CLS_OP: begin
                            n_mode  = iee_pkg::MODE_BYTE;
                            n_state = iee_pkg::S_PUSH;
                        end
                        iee_pkg::CLS_OPEN: begin
                            if (i_stat.level_full)
                                o_cmd.deep = 1'b1;
                            else
                                o_cmd.open_frame = 1'b1;
                        end
                        iee_pkg::CLS_CLOSE: begin
                            n_mode  = iee_pkg::MODE_CLOSE;
                            n_state = iee_pkg::S_PUSH;
                        end
                        iee_pkg::CLS_OTHER: o_cmd.badbyte = 1'b1;
                        default: ;
                    endcase
                end
            end
            iee_pkg::S_PUSH: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = iee_pkg::S_DIVW;
                end else begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_add = (r_mode != iee_pkg::MODE_BYTE);
                    n_state = after_push;
                end
            end
            iee_pkg::S_DIVW: begin
                if (i_stat.div_done)
                    n_state = iee_pkg::S_PUSHQ;
            end
            iee_pkg::S_PUSHQ: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_add = (r_mode != iee_pkg::MODE_BYTE);
                n_state = after_push;
            end
            iee_pkg::S_FIN: begin
                o_cmd.fin       = 1'b1;
                o_cmd.fin_close = (r_mode == iee_pkg::MODE_CLOSE);
                if (!i_stat.level_zero)
                    n_state = iee_pkg::S_POP;
                else if (r_mode == iee_pkg::MODE_CLOSE)
                    n_state = after_byte;
                else
                    n_state = iee_pkg::S_EMIT;
            end
            iee_pkg::S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = (r_mode == iee_pkg::MODE_CLOSE) ? after_byte : iee_pkg::S_PUSH;
            end
            iee_pkg::S_END: begin
                if (i_stat.stopped) begin
                    o_cmd.save_stop = 1'b1;
                    n_state = iee_pkg::S_EMIT;
                end else begin
                    n_mode  = iee_pkg::MODE_FINAL;
                    n_state = iee_pkg::S_PUSH;
                end
            end
            iee_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = iee_pkg::S_IDLE;
                end
            end
            default: n_state = iee_pkg::S_IDLE;
        endcase
    end

endmodule

### hdl/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an ASCII integer expression with + - * / and parentheses.
// ----------------------------------------------------------------------------
// Each byte is accepted, then executed before the next byte is taken; an operator
// adds a fold step, ')' adds a fold and a finish step, plus a pop when it closes a
// group, and a fold by '/' with a non-zero divisor waits on the bit-serial divider.
// After the last byte the result comes from a final fold and finish, plus a pop and
// fold for each frame still open (read, push, finish) and any divides.
// Synchronous active-low reset empties the result register and the control and term state.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int MAX_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iee_in_if.sink     i_in,
    iee_out_if.source  o_out
);

    iee_pkg::t_iee_cmd  w_cmd;
    iee_pkg::t_iee_stat w_stat;

    iee_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    iee_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

### hdl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_assert.svh"

module iee_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_result,
    input logic [1:0]  i_out_status
);

    // a held result stays put until taken
    `IEE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_result) && $stable(i_out_status))
    // an error result always carries zero
    `IEE_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_status != 2'd0, i_out_result == 32'd0)
    // one byte in flight: no accept in the cycle after an accept
    `IEE_ASSERT_NEXT(a_one_byte, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // reset empties the result register
    `IEE_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result),
    .i_out_status (o_out.status)
);
